// ===== hw/rtl/hks_pkg.sv =====
// Package for the HMAC-SHA-256 counter-mode keystream block.
// Holds the SHA-256 word types, round constants and round functions.
// No dependencies.
package hks_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] state_t;   // index 0 is a, index 7 is h
  typedef logic [15:0][31:0] block_t;  // index 0 is the first message word

  // Data words and the saturated byte count travel beside the hash.
  localparam int unsigned SIDE_W = 262;
  typedef logic [SIDE_W-1:0] side_t;

  localparam int unsigned IN_W  = 296;
  localparam int unsigned OUT_W = 264;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 8'd3;

  localparam logic [5:0] MAX_BYTES = 6'd32;
  localparam word_t IPAD = 32'h36363636;
  localparam word_t OPAD = 32'h5c5c5c5c;
  localparam word_t PAD_ONE = 32'h80000000;
  // Bit lengths of the inner (64+20 bytes) and outer (64+32 bytes) messages.
  localparam word_t INNER_BITS = 32'd672;
  localparam word_t OUTER_BITS = 32'd768;

  localparam state_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t k_const(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One compression round; wk is the schedule word plus the round constant.
  function automatic state_t sha_round(input state_t st, input word_t wk);
    state_t r;
    word_t t1;
    word_t t2;
    t1 = st[7] + (rotr(st[4], 6) ^ rotr(st[4], 11) ^ rotr(st[4], 25))
         + ((st[4] & st[5]) ^ (~st[4] & st[6])) + wk;
    t2 = (rotr(st[0], 2) ^ rotr(st[0], 13) ^ rotr(st[0], 22))
         + ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
    r[7] = st[6];
    r[6] = st[5];
    r[5] = st[4];
    r[4] = st[3] + t1;
    r[3] = st[2];
    r[2] = st[1];
    r[1] = st[0];
    r[0] = t1 + t2;
    return r;
  endfunction

  // Slides the sixteen-word schedule window by one word.
  function automatic block_t sched_shift(input block_t w);
    block_t r;
    word_t s0;
    word_t s1;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    for (int j = 0; j < 15; j++) r[j] = w[j+1];
    r[15] = w[0] + s0 + w[9] + s1;
    return r;
  endfunction

  function automatic state_t state_add(input state_t x, input state_t y);
    state_t r;
    for (int j = 0; j < 8; j++) r[j] = x[j] + y[j];
    return r;
  endfunction

endpackage

// ===== hw/rtl/hks_compress_pipe.sv =====
// Fully pipelined SHA-256 compression: one round per register stage.
// Depends on hks_pkg. Output is the working state after round 63.
module hks_compress_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  hks_pkg::state_t in_state,
  input  hks_pkg::block_t in_block,
  input  hks_pkg::side_t  in_side,
  output logic            out_valid,
  output hks_pkg::state_t out_state,
  output hks_pkg::side_t  out_side
);

  logic            v_r    [64];
  hks_pkg::state_t st_r   [64];
  hks_pkg::block_t w_r    [64];
  hks_pkg::side_t  side_r [64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      st_r[0]   <= hks_pkg::sha_round(in_state, in_block[0] + hks_pkg::k_const(6'd0));
      w_r[0]    <= hks_pkg::sched_shift(in_block);
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 1; s < 64; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
      if (en) begin
        st_r[s]   <= hks_pkg::sha_round(st_r[s-1],
                       w_r[s-1][0] + hks_pkg::k_const(6'(s)));
        w_r[s]    <= hks_pkg::sched_shift(w_r[s-1]);
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_valid = v_r[63];
  assign out_state = st_r[63];
  assign out_side  = side_r[63];

endmodule

// ===== hw/rtl/hks_key_sched.sv =====
// Iterative SHA-256 unit that hashes the key-xor-ipad and key-xor-opad blocks.
// Depends on hks_pkg. Runs after reset and after every key register write.
module hks_key_sched (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            restart,
  input  logic [63:0]     key_high,
  input  logic [63:0]     key_low,
  output logic            busy,
  output hks_pkg::state_t ipad_state,
  output hks_pkg::state_t opad_state
);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_IDLE = 2'd3;

  logic [1:0]      state_r;
  logic            phase_r;
  logic [5:0]      rnd_r;
  hks_pkg::state_t st_r;
  hks_pkg::block_t w_r;
  hks_pkg::state_t ipad_r;
  hks_pkg::state_t opad_r;
  hks_pkg::block_t blk;
  hks_pkg::word_t  pad;

  always_comb begin
    pad = phase_r ? hks_pkg::OPAD : hks_pkg::IPAD;
    for (int j = 0; j < 16; j++) blk[j] = pad;
    blk[0] = key_high[63:32] ^ pad;
    blk[1] = key_high[31:0] ^ pad;
    blk[2] = key_low[63:32] ^ pad;
    blk[3] = key_low[31:0] ^ pad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r <= S_LOAD;
      phase_r <= 1'b0;
      rnd_r   <= 6'd0;
    end else begin
      case (state_r)
        S_LOAD: begin
          state_r <= S_RUN;
          rnd_r   <= 6'd0;
        end
        S_RUN: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= S_FIN;
        end
        S_FIN: begin
          phase_r <= 1'b1;
          state_r <= phase_r ? S_IDLE : S_LOAD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: begin
        st_r <= hks_pkg::H_INIT;
        w_r  <= blk;
      end
      S_RUN: begin
        st_r <= hks_pkg::sha_round(st_r, w_r[0] + hks_pkg::k_const(rnd_r));
        w_r  <= hks_pkg::sched_shift(w_r);
      end
      S_FIN: begin
        if (phase_r) opad_r <= hks_pkg::state_add(hks_pkg::H_INIT, st_r);
        else ipad_r <= hks_pkg::state_add(hks_pkg::H_INIT, st_r);
      end
      default: ;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign ipad_state = ipad_r;
  assign opad_state = opad_r;

endmodule

// ===== hw/rtl/hmac_ctr_keystream_xor.sv =====
// HMAC-SHA-256 counter-mode keystream XOR, one 32-byte block per beat.
// Each input beat passes through 64 inner rounds, one digest add stage, 64
// outer rounds and an output register. Throughput: one beat per cycle; the
// whole pipeline stalls while the output beat waits.
// Reset and every key write start a pad precompute that holds
// in_tready low; control and register-file state resets to zero, datapath does not.
module hmac_ctr_keystream_xor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // block_index[31:0], data_word0..3 [95:32]..[287:224], valid_bytes[293:288]
  input  logic [hks_pkg::IN_W-1:0]         in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_word0..3 [63:0]..[255:192], out_valid_bytes[261:256]
  output logic [hks_pkg::OUT_W-1:0]        out_tdata,
  input  logic                             cfg_tvalid,
  output logic                             cfg_tready,
  input  logic [hks_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                      cfg_data
);

  logic [63:0] key_high_r, key_low_r, nonce_high_r, nonce_low_r;
  logic        cfg_wr, key_wr, busy, en, acc;
  hks_pkg::state_t ipad_st, opad_st, a_st, b_st;
  hks_pkg::block_t a_blk;
  hks_pkg::side_t  in_side, a_side, b_side;
  logic        a_v, b_v;
  logic [5:0]  in_cnt;

  logic            mid_v_r;
  hks_pkg::block_t mid_blk_r;
  hks_pkg::side_t  mid_side_r;
  logic            out_v_r;
  logic [hks_pkg::OUT_W-1:0] out_d_r;

  assign cfg_tready = 1'b1;
  assign cfg_wr = cfg_tvalid && cfg_tready;
  assign key_wr = cfg_wr && (cfg_index == hks_pkg::REG_KEY_HIGH ||
                             cfg_index == hks_pkg::REG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r   <= '0;
      key_low_r    <= '0;
      nonce_high_r <= '0;
      nonce_low_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        hks_pkg::REG_KEY_HIGH:   key_high_r   <= cfg_data;
        hks_pkg::REG_KEY_LOW:    key_low_r    <= cfg_data;
        hks_pkg::REG_NONCE_HIGH: nonce_high_r <= cfg_data;
        hks_pkg::REG_NONCE_LOW:  nonce_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  hks_key_sched u_key (
    .clk(clk), .rst_n(rst_n), .restart(key_wr),
    .key_high(key_high_r), .key_low(key_low_r),
    .busy(busy), .ipad_state(ipad_st), .opad_state(opad_st)
  );

  assign en        = !out_v_r || out_tready;
  assign in_tready = en && !busy;
  assign acc       = in_tvalid && in_tready;

  assign in_cnt  = (in_tdata[293:288] > hks_pkg::MAX_BYTES) ? hks_pkg::MAX_BYTES
                                                           : in_tdata[293:288];
  assign in_side = {in_cnt, in_tdata[95:32], in_tdata[159:96],
                    in_tdata[223:160], in_tdata[287:224]};

  // Second inner block: nonce, counter, padding, length.
  always_comb begin
    a_blk     = '0;
    a_blk[0]  = nonce_high_r[63:32];
    a_blk[1]  = nonce_high_r[31:0];
    a_blk[2]  = nonce_low_r[63:32];
    a_blk[3]  = nonce_low_r[31:0];
    a_blk[4]  = in_tdata[31:0];
    a_blk[5]  = hks_pkg::PAD_ONE;
    a_blk[15] = hks_pkg::INNER_BITS;
  end

  hks_compress_pipe u_inner (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(acc),
    .in_state(ipad_st), .in_block(a_blk), .in_side(in_side),
    .out_valid(a_v), .out_state(a_st), .out_side(a_side)
  );

  // Inner digest becomes the second outer block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r <= 1'b0;
    end else if (en) begin
      mid_v_r <= a_v;
    end
    if (en) begin
      for (int j = 0; j < 8; j++) mid_blk_r[j] <= ipad_st[j] + a_st[j];
      for (int j = 9; j < 15; j++) mid_blk_r[j] <= '0;
      mid_blk_r[8]  <= hks_pkg::PAD_ONE;
      mid_blk_r[15] <= hks_pkg::OUTER_BITS;
      mid_side_r    <= a_side;
    end
  end

  hks_compress_pipe u_outer (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(mid_v_r),
    .in_state(opad_st), .in_block(mid_blk_r), .in_side(mid_side_r),
    .out_valid(b_v), .out_state(b_st), .out_side(b_side)
  );

  logic [255:0] ks, res, mask;
  logic [5:0]   b_cnt;

  always_comb begin
    b_cnt = b_side[261:256];
    for (int j = 0; j < 8; j++) ks[255-32*j -: 32] = opad_st[j] + b_st[j];
    // Byte 0 sits in the top bits of the block.
    for (int i = 0; i < 32; i++) mask[255-8*i -: 8] = (6'(i) < b_cnt) ? 8'hff : 8'h00;
    res = (b_side[255:0] ^ ks) & mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= b_v;
    end
    if (en) begin
      out_d_r <= {2'b00, b_cnt, res[63:0], res[127:64], res[191:128], res[255:192]};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

// ===== hw/rtl/hks_checker.sv =====
// Port-level checks for hmac_ctr_keystream_xor, attached by bind.
// Depends on hks_pkg.
module hks_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [hks_pkg::OUT_W-1:0]     out_tdata,
  input logic                          cfg_tvalid,
  input logic                          cfg_tready,
  input logic [hks_pkg::CFG_IDX_W-1:0] cfg_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[261:256] <= hks_pkg::MAX_BYTES)
    else $error("byte count not saturated");

  a_zero_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[261:256] == 6'd0 |-> out_tdata[255:0] == '0)
    else $error("empty block carries data");

  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_tvalid && cfg_tready &&
    (cfg_index == hks_pkg::REG_KEY_HIGH || cfg_index == hks_pkg::REG_KEY_LOW)
    |=> !in_tready)
    else $error("input accepted during pad precompute");

endmodule

bind hmac_ctr_keystream_xor hks_checker u_chk (.*);
